// ===== sv/xs256_pkg.sv =====
// ----------------------------------------------------------------------------
// xs256_pkg
// Shared types, constants and the state update of the xoshiro256+ generator.
// ----------------------------------------------------------------------------
package xs256_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = 4;
  localparam int unsigned HalfW    = WordW / 2;
  localparam int unsigned RotAmt   = 45;
  localparam int unsigned ShiftT   = 17;
  localparam int unsigned JumpLen  = 256;
  localparam int unsigned JumpCntW = $clog2(JumpLen);

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] gen_words_t;

  typedef enum logic [1:0] {
    OP_SEED      = 2'd0,
    OP_NEXT      = 2'd1,
    OP_JUMP      = 2'd2,
    OP_LONG_JUMP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX_A,
    ST_MIX_B,
    ST_JUMP
  } state_e;

  localparam word_t GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam word_t MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam word_t MIX_MUL_B   = 64'h94d049bb133111eb;

  // Element 0 is the first polynomial word, as the jump walks it.
  localparam gen_words_t POLY_SHORT = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };

  localparam gen_words_t POLY_LONG = {
    64'h39109bb02acbe69d, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
  };

  // One step of the generator: xor, shift and rotate.
  function automatic gen_words_t xs_advance(gen_words_t s);
    gen_words_t r;
    word_t      t;
    t    = s[1] << ShiftT;
    r    = s;
    r[2] = r[2] ^ r[0];
    r[3] = r[3] ^ r[1];
    r[1] = r[1] ^ r[2];
    r[0] = r[0] ^ r[3];
    r[2] = r[2] ^ t;
    r[3] = {r[3][WordW-1-RotAmt:0], r[3][WordW-1:WordW-RotAmt]};
    return r;
  endfunction

endpackage

// ===== sv/xs256_if.sv =====
// ----------------------------------------------------------------------------
// xs256 channel interfaces
// Valid/ready channels for requests into and words out of the generator.
// ----------------------------------------------------------------------------
interface xs256_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] seed_value;

  modport source (output valid, output op, output seed_value, input ready);
  modport sink (input valid, input op, input seed_value, output ready);
endinterface

interface xs256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

// ===== sv/xs256_mul.sv =====
// ----------------------------------------------------------------------------
// xs256_mul
// Iterative 64 x 64 multiplier giving the low 64 bits of the product through
// one shared 32 x 32 multiplier, one partial product at a time.
// ----------------------------------------------------------------------------
module xs256_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  xs256_pkg::word_t     a_i,
  input  xs256_pkg::word_t     b_i,
  output logic                 done_o,
  output xs256_pkg::word_t     product_o
);
  import xs256_pkg::*;

  word_t              a_q, a_d;
  word_t              b_q, b_d;
  word_t              acc_q, acc_d;
  logic [1:0]         step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [HalfW-1:0]   opa, opb;
  logic [WordW-1:0]   part;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;

    // Low x low first, then the two cross terms land on the upper half.
    case (step_q)
      2'd0:    begin opa = a_q[HalfW-1:0];     opb = b_q[HalfW-1:0];     end
      2'd1:    begin opa = a_q[HalfW-1:0];     opb = b_q[WordW-1:HalfW]; end
      default: begin opa = a_q[WordW-1:HalfW]; opb = b_q[HalfW-1:0];     end
    endcase
    part = WordW'(opa) * WordW'(opb);

    if (busy_q) begin
      if (step_q == 2'd0) begin
        acc_d = part;
      end else begin
        acc_d = acc_q + {part[HalfW-1:0], {HalfW{1'b0}}};
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      step_d = 2'd0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== sv/xoshiro256_plus_generator.sv =====
// ----------------------------------------------------------------------------
// xoshiro256_plus_generator
// xoshiro256+ generator with seeding through splitmix64 and jump operations.
// ----------------------------------------------------------------------------
// Next requests stream one per cycle while the output register is being
// drained; the word is the sum of words 0 and 3 taken before the state
// advances. A seed runs four splitmix64 rounds, each made of two passes
// through the shared multiplier. Jump and long jump walk all polynomial
// bits, one bit per cycle. Seed and jumps produce no output word. The
// state is zero after reset, so a seed should come first.
module xoshiro256_plus_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  xs256_in_if.sink    req_i,
  xs256_out_if.source rsp_o
);
  import xs256_pkg::*;

  state_e              state_q, state_d;
  gen_words_t          gen_q, gen_d;
  gen_words_t          acc_q, acc_d;
  gen_words_t          acc_nxt;
  word_t               z_q, z_d;
  word_t               word_q, word_d;
  logic [1:0]          idx_q, idx_d;
  logic [JumpCntW-1:0] cnt_q, cnt_d;
  logic                long_q, long_d;
  logic                out_valid_q, out_valid_d;
  logic                in_ready;
  logic                poly_bit;
  logic                mul_start;
  word_t               mul_a, mul_b;
  logic                mul_done;
  word_t               mul_p;

  xs256_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_p)
  );

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    acc_d       = acc_q;
    z_d         = z_q;
    word_d      = word_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    long_d      = long_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    in_ready    = 1'b0;
    mul_start   = 1'b0;
    mul_a       = z_q ^ (z_q >> 30);
    mul_b       = MIX_MUL_A;

    poly_bit = long_q ? POLY_LONG[cnt_q[JumpCntW-1:JumpCntW-2]][cnt_q[JumpCntW-3:0]]
                      : POLY_SHORT[cnt_q[JumpCntW-1:JumpCntW-2]][cnt_q[JumpCntW-3:0]];
    acc_nxt  = poly_bit ? (acc_q ^ gen_q) : acc_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready = !out_valid_q || rsp_o.ready;
        if (req_i.valid && in_ready) begin
          unique case (op_e'(req_i.op))
            OP_SEED: begin
              z_d     = req_i.seed_value + GOLDEN_STEP;
              idx_d   = 2'd0;
              state_d = ST_SEED;
            end
            OP_NEXT: begin
              word_d      = gen_q[0] + gen_q[3];
              out_valid_d = 1'b1;
              gen_d       = xs_advance(gen_q);
            end
            OP_JUMP, OP_LONG_JUMP: begin
              long_d  = (op_e'(req_i.op) == OP_LONG_JUMP);
              cnt_d   = '0;
              acc_d   = '0;
              state_d = ST_JUMP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEED: begin
        mul_start = 1'b1;
        state_d   = ST_MIX_A;
      end
      ST_MIX_A: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_p ^ (mul_p >> 27);
          mul_b     = MIX_MUL_B;
          state_d   = ST_MIX_B;
        end
      end
      ST_MIX_B: begin
        if (mul_done) begin
          gen_d[idx_q] = mul_p ^ (mul_p >> 31);
          z_d          = z_q + GOLDEN_STEP;
          idx_d        = idx_q + 2'd1;
          state_d      = (idx_q == 2'd3) ? ST_IDLE : ST_SEED;
        end
      end
      ST_JUMP: begin
        acc_d = acc_nxt;
        cnt_d = cnt_q + JumpCntW'(1);
        // On the last polynomial bit the accumulated words become the state.
        if (cnt_q == {JumpCntW{1'b1}}) begin
          gen_d   = acc_nxt;
          state_d = ST_IDLE;
        end else begin
          gen_d = xs_advance(gen_q);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      cnt_q       <= '0;
      long_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      long_q      <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    z_q    <= z_d;
    word_q <= word_d;
  end

  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.random_word = word_q;

endmodule

// ===== sv/xs256_checker.sv =====
// ----------------------------------------------------------------------------
// xs256_checker
// Port-level checks on the generator's request and output channels.
// ----------------------------------------------------------------------------
module xs256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_word_i
);
  import xs256_pkg::*;

  logic in_xfer;
  logic is_next;
  logic is_jump;

  assign in_xfer = in_valid_i && in_ready_i;
  assign is_next = (op_e'(in_op_i) == OP_NEXT);
  assign is_jump = (op_e'(in_op_i) == OP_JUMP) || (op_e'(in_op_i) == OP_LONG_JUMP);

  // A stalled output word must hold until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("output word changed while stalled");

  // A word only appears after a next request was transferred.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer && is_next))
    else $error("output word without a next request");

  // Seed and jumps occupy the sequencer, so the request side closes.
  a_busy_after_long_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !is_next |=> !in_ready_i)
    else $error("request accepted while a long operation runs");

  // A jump walks all polynomial bits before the next request is taken.
  a_jump_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && is_jump |-> ##256 !in_ready_i)
    else $error("jump finished early");

  // Every next transfer leaves a word waiting in the output register.
  a_next_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && is_next |=> out_valid_i)
    else $error("next request produced no word");

endmodule

bind xoshiro256_plus_generator xs256_checker u_xs256_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_op_i     (req_i.op),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_word_i  (rsp_o.random_word)
);
